>>> design/sacl_pkg.sv
// sacl_pkg: shared types and codes for the set associative lru cache model
// depends on nothing
`default_nettype none
package sacl_pkg;
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_FETCH  = 2'd3;

    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;
    localparam logic [1:0] OUT_IGN   = 2'd3;

    localparam logic [1:0] CFG_SET_BITS = 2'd0;
    localparam logic [1:0] CFG_OFF_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS     = 2'd2;

    localparam logic [2:0] RANK_MAX = 3'd7;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_WRITE
    } bk_state_t;
endpackage
`default_nettype wire

>>> design/set_assoc_cache_lru_sim_unit.sv
// set_assoc_cache_lru_sim_unit: top level of the lru cache model
// uses sacl_pkg, sacl_front, sacl_back (and sacl_ram through sacl_back)
`default_nettype none
// Trace driven set associative cache model with lru replacement. Each access
// transfer is split into set and tag in the front part and queued (two
// entries); the back part reads the set's tag row from per-way rams and the
// set's valid/rank row from one more ram, decides hit, fill or eviction and
// writes tag, valid bits and recency back. Each access passes the back states
// issue, row read and update, and no new access is taken until the
// read-modify-write of the set's rows is done. Results wait in an output
// register while the next access proceeds, unless a stalled result holds it
// back. After reset the back part runs a clearing pass over the valid/rank
// ram, one set per cycle over all sets (256 with the default parameters);
// accesses are queued but not processed until it finishes. Configuration
// must be written only while the block is idle; the block does not enforce it.
module set_assoc_cache_lru_sim_unit #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS = 8,
    parameter int TAG_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [63:0] address,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       outcome,
    output logic [2:0]       way_used,
    output logic [31:0]      evicted_tag,
    output logic             modify_extra_hit,
    output logic [31:0]      hit_total,
    output logic [31:0]      miss_total,
    output logic [31:0]      eviction_total,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import sacl_pkg::*;

    // set field is kept at least one bit wide so the rams have an address
    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

    logic [3:0] sb_reg, wy_reg;
    logic [5:0] ob_reg;
    logic [3:0] sb_eff;
    logic q_valid, q_pop;
    logic [1:0] q_op;
    logic [SET_W-1:0] q_set;
    logic [TAG_WIDTH-1:0] q_tag;

    assign cfg_ready = 1'b1;
    // with a set field of zero maximum width, force zero set bits
    assign sb_eff = (MAX_SET_BITS > 0) ? sb_reg : 4'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_reg <= 4'd0; ob_reg <= 6'd0; wy_reg <= 4'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SET_BITS: sb_reg <= cfg_data[3:0];
                CFG_OFF_BITS: ob_reg <= cfg_data[5:0];
                CFG_WAYS:     wy_reg <= cfg_data[3:0];
                default:      ;
            endcase
        end
    end

    sacl_front #(.SET_W(SET_W), .TAG_WIDTH(TAG_WIDTH)) u_front (
        .clk, .rst_n, .in_valid, .in_stall, .operation, .address,
        .set_bits(sb_eff), .off_bits(ob_reg),
        .q_valid, .q_pop, .q_op, .q_set, .q_tag
    );

    sacl_back #(.SET_W(SET_W), .WAYS(MAX_WAYS), .TAG_WIDTH(TAG_WIDTH)) u_back (
        .clk, .rst_n, .q_valid, .q_pop, .q_op, .q_set, .q_tag,
        .ways_cfg(wy_reg), .out_valid, .out_stall, .outcome, .way_used,
        .evicted_tag, .modify_extra_hit, .hit_total, .miss_total, .eviction_total
    );

    // a full output register that is stalled stays valid and keeps its hit total
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit_total))
        else $error("result changed while stalled");
    // only an eviction reports an evicted tag
    a_ev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && outcome != OUT_EVICT |-> evicted_tag == 32'd0)
        else $error("evicted tag without eviction");
    // misses never fall below evictions
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> miss_total >= eviction_total)
        else $error("eviction count exceeds miss count");
endmodule
`default_nettype wire

>>> design/sacl_ram.sv
// sacl_ram: generic simple dual port ram, one write and one registered read
// depends on nothing
`default_nettype none
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> design/sacl_front.sv
// sacl_front: accepts trace accesses, splits address into set and tag,
// pushes them into a two entry queue; uses sacl_pkg
`default_nettype none
module sacl_front #(
    parameter int SET_W = 8,
    parameter int TAG_WIDTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           operation,
    input  wire logic [63:0]          address,
    input  wire logic [3:0]           set_bits,
    input  wire logic [5:0]           off_bits,
    output logic                      q_valid,
    input  wire logic                 q_pop,
    output logic [1:0]                q_op,
    output logic [SET_W-1:0]          q_set,
    output logic [TAG_WIDTH-1:0]      q_tag
);
    import sacl_pkg::*;

    localparam int EW = 2 + SET_W + TAG_WIDTH;

    logic [EW-1:0] ent_reg [2];
    logic          rd_reg, rd_next, wr_reg, wr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic [4:0]    s;
    logic [6:0]    sb;
    logic [63:0]   tag_sh, set_sh, set_mask;
    logic          push;

    always_comb
    begin
        s = ({1'b0, set_bits} > 5'(SET_W)) ? 5'(SET_W) : {1'b0, set_bits};
        sb = 7'(s) + 7'(off_bits);
        tag_sh = sb[6] ? 64'd0 : (address >> sb[5:0]);
        set_sh = address >> off_bits;
        set_mask = (64'd1 << s) - 64'd1;
        set_sh = set_sh & set_mask;
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign {q_op, q_set, q_tag} = ent_reg[rd_reg];

    always_comb
    begin
        rd_next  = rd_reg ^ (q_pop && q_valid);
        wr_next  = wr_reg ^ push;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_reg] <= {operation, set_sh[SET_W-1:0], tag_sh[TAG_WIDTH-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

>>> design/sacl_back.sv
// sacl_back: per access set lookup, lru update and counters
// uses sacl_pkg and sacl_ram for the tag store and the per-set valid/rank row
`default_nettype none
module sacl_back #(
    parameter int SET_W = 8,
    parameter int WAYS = 8,
    parameter int TAG_WIDTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    output logic                      q_pop,
    input  wire logic [1:0]           q_op,
    input  wire logic [SET_W-1:0]     q_set,
    input  wire logic [TAG_WIDTH-1:0] q_tag,
    input  wire logic [3:0]           ways_cfg,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [1:0]                outcome,
    output logic [2:0]                way_used,
    output logic [31:0]               evicted_tag,
    output logic                      modify_extra_hit,
    output logic [31:0]               hit_total,
    output logic [31:0]               miss_total,
    output logic [31:0]               eviction_total
);
    import sacl_pkg::*;

    localparam int NSETS = 1 << SET_W;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    // row layout: valid bits in the low WAYS bits, then three rank bits per way
    localparam int MW = WAYS * 4;

    bk_state_t st_reg, st_next;
    logic [SET_W-1:0] clr_reg, clr_next;
    logic [TAG_WIDTH-1:0] rtag [WAYS];
    logic [MW-1:0] row_rd, row_wr;
    logic          row_we;
    logic [SET_W-1:0] row_waddr;
    logic [WAYS-1:0] vld;
    logic [2:0]  rank [WAYS];
    logic [2:0]  rank_new [WAYS];
    logic [31:0] hit_reg, miss_reg, ev_reg;
    logic [1:0]  oc_reg;
    logic [2:0]  ow_reg;
    logic [31:0] oe_reg;
    logic        om_reg, ov_reg;
    logic [1:0]  op_reg;
    logic [SET_W-1:0] set_reg;
    logic [TAG_WIDTH-1:0] tag_reg;

    logic [6:0]  nways;
    logic [WW-1:0] hw, ew, fw, vw;
    logic        hit, empt;
    logic [2:0]  best, old;
    logic        wr_en;
    logic [1:0]  oc_n;

    genvar g;
    generate
        for (g = 0; g < WAYS; g++)
        begin : g_way
            sacl_ram #(.WIDTH(TAG_WIDTH), .DEPTH(NSETS)) u_tag (
                .clk(clk),
                .we(wr_en && (vw == WW'(g))),
                .waddr(set_reg),
                .wdata(tag_reg),
                .raddr(set_reg),
                .rdata(rtag[g])
            );
        end
    endgenerate

    sacl_ram #(.WIDTH(MW), .DEPTH(NSETS)) u_row (
        .clk(clk),
        .we(row_we),
        .waddr(row_waddr),
        .wdata(row_wr),
        .raddr(set_reg),
        .rdata(row_rd)
    );

    // unpack the registered row
    always_comb
    begin
        for (int k = 0; k < WAYS; k++)
        begin
            vld[k] = row_rd[k];
            rank[k] = row_rd[WAYS + 3 * k +: 3];
        end
    end

    // way lookup over the registered row
    always_comb
    begin
        nways = (ways_cfg == 4'd0) ? 7'd1 : ((7'(ways_cfg) > 7'(WAYS)) ? 7'(WAYS) : 7'(ways_cfg));
        hit = 1'b0; hw = '0; empt = 1'b0; fw = '0; best = 3'd0; ew = '0;
        for (int k = WAYS - 1; k >= 0; k--)
        begin
            if (7'(k) < nways)
            begin
                if (vld[k] && rtag[k] == tag_reg)
                begin
                    hit = 1'b1; hw = WW'(k);
                end
                if (!vld[k])
                begin
                    empt = 1'b1; fw = WW'(k);
                end
            end
        end
        for (int k = 0; k < WAYS; k++)
        begin
            if (7'(k) < nways && rank[k] > best)
            begin
                best = rank[k]; ew = WW'(k);
            end
        end
        vw = hit ? hw : (empt ? fw : ew);
        oc_n = hit ? OUT_HIT : (empt ? OUT_FILL : OUT_EVICT);
        old = (oc_n == OUT_FILL) ? RANK_MAX : rank[vw];
    end

    // new row: touched way most recent, younger valid ways age by one
    always_comb
    begin
        row_wr = '0;
        for (int k = 0; k < WAYS; k++)
        begin
            if (WW'(k) == vw)
                rank_new[k] = 3'd0;
            else if (7'(k) < nways && vld[k]
                     && (oc_n == OUT_FILL || rank[k] < old)
                     && rank[k] < RANK_MAX)
                rank_new[k] = rank[k] + 3'd1;
            else
                rank_new[k] = rank[k];
        end
        if (st_reg != BK_CLEAR)
        begin
            for (int k = 0; k < WAYS; k++)
            begin
                row_wr[k] = vld[k] | (WW'(k) == vw);
                row_wr[WAYS + 3 * k +: 3] = rank_new[k];
            end
        end
    end

    always_comb
    begin
        st_next = st_reg;
        clr_next = clr_reg;
        case (st_reg)
            BK_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1) st_next = BK_IDLE;
            end
            BK_IDLE:  if (q_valid && !(ov_reg && out_stall)) st_next = BK_READ;
            BK_READ:  st_next = BK_WRITE;
            BK_WRITE: st_next = BK_IDLE;
            default:  st_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = (st_reg == BK_IDLE) && q_valid && !(ov_reg && out_stall);
        wr_en = (st_reg == BK_WRITE) && (op_reg != OP_FETCH) && !hit;
        row_we = (st_reg == BK_CLEAR) || ((st_reg == BK_WRITE) && (op_reg != OP_FETCH));
        row_waddr = (st_reg == BK_CLEAR) ? clr_reg : set_reg;
    end

    function automatic logic [31:0] sat(input logic [31:0] c, input logic inc);
        sat = (inc && c != CNT_MAX) ? c + 32'd1 : c;
    endfunction

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg <= q_op; set_reg <= q_set; tag_reg <= q_tag;
        end
        if (st_reg == BK_WRITE)
        begin
            if (op_reg == OP_FETCH)
            begin
                oc_reg <= OUT_IGN; ow_reg <= 3'd0; oe_reg <= 32'd0;
            end
            else
            begin
                oc_reg <= oc_n; ow_reg <= 3'(vw);
                oe_reg <= (oc_n == OUT_EVICT) ? 32'(rtag[vw]) : 32'd0;
            end
            om_reg <= (op_reg == OP_MODIFY);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= BK_CLEAR; clr_reg <= '0; ov_reg <= 1'b0;
            hit_reg <= '0; miss_reg <= '0; ev_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            clr_reg <= clr_next;
            if (ov_reg && !out_stall) ov_reg <= 1'b0;
            if (st_reg == BK_WRITE)
            begin
                ov_reg <= 1'b1;
                if (op_reg != OP_FETCH)
                begin
                    hit_reg  <= sat(sat(hit_reg, hit), op_reg == OP_MODIFY);
                    miss_reg <= sat(miss_reg, !hit);
                    ev_reg   <= sat(ev_reg, oc_n == OUT_EVICT);
                end
            end
        end
    end

    assign out_valid = ov_reg;
    assign outcome = oc_reg;
    assign way_used = ow_reg;
    assign evicted_tag = oe_reg;
    assign modify_extra_hit = om_reg;
    assign hit_total = hit_reg;
    assign miss_total = miss_reg;
    assign eviction_total = ev_reg;
endmodule
`default_nettype wire
